### hw/rtl/mctw_pkg.sv
// Shared constants, codes and the token type of the client watchdog chain.
package mctw_pkg;

   localparam int MAX_CLIENTS = 16;
   localparam int COUNT_BITS = 16;
   localparam int ID_W = 22;
   localparam int STALE_SLOT_W = 4;
   localparam int NUM_W = $clog2(MAX_CLIENTS + 1);

   typedef enum logic [1:0] {
      REQ_REGISTER = 2'd0,
      REQ_KICK = 2'd1,
      REQ_CHECK = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_TRIGGERED = 2'd1,
      ST_FULL = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_WALK
   } walk_state_type;

   // Token that travels one cell per cycle down the chain.
   typedef struct packed {
      logic valid;
      req_code_type op;
      logic [ID_W-1:0] id;
      logic done;
      status_type status;
      logic [ID_W-1:0] sid;
      logic [STALE_SLOT_W-1:0] sslot;
   } token_type;

endpackage

### hw/rtl/mctw_if.sv
// Valid/ready channel interfaces for requests and responses.
interface mctw_req_if
   import mctw_pkg::*;
;
   logic valid;
   logic ready;
   logic [1:0] req_type;
   logic [ID_W-1:0] client_id;

   modport source (output valid, output req_type, output client_id, input ready);
   modport sink (input valid, input req_type, input client_id, output ready);
endinterface

interface mctw_rsp_if
   import mctw_pkg::*;
;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [ID_W-1:0] stale_id;
   logic [STALE_SLOT_W-1:0] stale_slot;

   modport source (output valid, output status, output stale_id, output stale_slot,
                   input ready);
   modport sink (input valid, input status, input stale_id, input stale_slot,
                 output ready);
endinterface

### hw/rtl/mctw_cell.sv
// One watchdog channel: id, kick counter and snapshot, plus a token stage.
module mctw_cell
   import mctw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    live,
   input  logic                    tail,
   input  logic [STALE_SLOT_W-1:0] slot_tag,
   input  token_type               token_in,
   output token_type               token_out
);

   logic [ID_W-1:0] id_ff, id_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] snap_ff, snap_in;
   token_type token_ff, token_in_next;
   logic act;

   always_comb begin
      id_in = id_ff;
      count_in = count_ff;
      snap_in = snap_ff;
      token_in_next = token_in;
      act = token_in.valid && !token_in.done;
      if (act) begin
         case (token_in.op)
            REQ_REGISTER: begin
               if (tail) begin
                  id_in = token_in.id;
                  count_in = '0;
                  snap_in = '0;
                  token_in_next.done = 1'b1;
               end
            end
            REQ_KICK: begin
               if (live && id_ff == token_in.id) begin
                  count_in = count_ff + COUNT_BITS'(1);
                  token_in_next.done = 1'b1;
               end
            end
            REQ_CHECK: begin
               if (live) begin
                  if (count_ff == snap_ff) begin
                     token_in_next.done = 1'b1;
                     token_in_next.status = ST_TRIGGERED;
                     token_in_next.sid = id_ff;
                     token_in_next.sslot = slot_tag;
                  end else begin
                     snap_in = count_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      count_ff <= count_in;
      snap_ff <= snap_in;
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

### hw/rtl/mctw_chain.sv
// Row of watchdog cells; derives live and tail flags from the fill count.
module mctw_chain
   import mctw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [NUM_W-1:0] reg_count,
   input  token_type        token_head,
   output token_type        token_exit
);

   token_type links [MAX_CLIENTS+1];

   assign links[0] = token_head;

   for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
      mctw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .live      (NUM_W'(i) < reg_count),
         .tail      (NUM_W'(i) == reg_count),
         .slot_tag  (STALE_SLOT_W'(i)),
         .token_in  (links[i]),
         .token_out (links[i+1])
      );
   end

   assign token_exit = links[MAX_CLIENTS];

endmodule

### hw/rtl/multi_channel_thread_watchdog.sv
// A transaction walks the MAX_CLIENTS cells, one per cycle; the response is
// registered when the token leaves the last cell.
// Only one token is in the chain at a time: a new transaction is accepted only
// in the idle state, after the previous one has left the last cell.
// Reset: synchronous, active high; clears the fill count, the walk state, the
// token valid bits and the response valid bit. Channel storage is not cleared.
module multi_channel_thread_watchdog
   import mctw_pkg::*;
(
   input logic clock,
   input logic reset,
   mctw_req_if.sink req_port,
   mctw_rsp_if.source rsp_port
);

   walk_state_type state_ff, state_in;
   logic [NUM_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [STALE_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   token_type token_head, token_exit;
   logic accept;
   logic out_free;
   status_type exit_status;

   // Accept only when the response register will be empty by the end of the walk.
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   mctw_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .reg_count  (count_ff),
      .token_head (token_head),
      .token_exit (token_exit)
   );

   // Build the token injected into the first cell.
   always_comb begin
      token_head.valid = accept;
      token_head.op = req_code_type'(req_port.req_type);
      token_head.id = req_port.client_id;
      token_head.done = 1'b0;
      token_head.status = ST_OK;
      token_head.sid = '0;
      token_head.sslot = '0;
      // A full table answers ST_FULL: mark the token done so no cell acts.
      if (req_code_type'(req_port.req_type) == REQ_REGISTER &&
          count_ff == NUM_W'(MAX_CLIENTS)) begin
         token_head.done = 1'b1;
         token_head.status = ST_FULL;
      end
   end

   // A kick that passed every cell untouched had no matching id.
   always_comb begin
      exit_status = token_exit.status;
      if (token_exit.op == REQ_KICK && !token_exit.done) begin
         exit_status = ST_NOT_FOUND;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_port.ready = 1'b0;
      accept = 1'b0;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in = rsp_id_ff;
      rsp_slot_in = rsp_slot_ff;

      // Drop the response once the sink takes it.
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_port.ready = out_free;
            accept = req_port.valid && out_free;
            if (accept) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // Token leaves the last cell: capture the response.
            if (token_exit.valid) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_status_in = exit_status;
               rsp_id_in = token_exit.sid;
               rsp_slot_in = token_exit.sslot;
               // Advance the fill count after the tail cell stored the new channel.
               if (token_exit.op == REQ_REGISTER && token_exit.status == ST_OK) begin
                  count_in = count_ff + NUM_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff <= rsp_id_in;
      rsp_slot_ff <= rsp_slot_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.status = rsp_status_ff;
   assign rsp_port.stale_id = rsp_id_ff;
   assign rsp_port.stale_slot = rsp_slot_ff;

endmodule
